// ----- hw/rtl/sp2c_pkg.sv -----
// sp2c_pkg: shared sizes, constants, types and the arctan table for the
// scan polar-to-cartesian converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sp2c_pkg;

  localparam int RANGE_BITS    = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int MAX_POINTS    = 4096;
  localparam int CORDIC_STAGES = 16;

  localparam int RANGE_IN_W = 16;
  localparam int IDX_W      = 12;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_W      = 17;

  // datapath sizes; x,y are Q30 mm with room for the CORDIC gain
  localparam int XY_W      = RANGE_BITS + 32;
  localparam int Z_W       = 34;
  localparam int RES_Z_W   = 34 - CORDIC_STAGES;
  localparam int STAGE_W   = 5;
  localparam int ATAN_W    = 31;
  localparam int GAIN_W    = 30;
  localparam int HALF_PI_W = 31;

  localparam logic [GAIN_W-1:0]    GAIN_Q30    = 30'h26DD3B6A;
  localparam logic [HALF_PI_W-1:0] HALF_PI_Q30 = 31'h6487ED51;
  localparam int OUT_LIMIT = 65535;

  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 8'd1;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             quad;
    logic                   last;
  } cordic_t;

  localparam logic [ATAN_W-1:0] ATAN_TAB [32] = '{
    31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6,
    31'h03FEAB76, 31'h01FFD55B, 31'h00FFFAAA, 31'h007FFF55,
    31'h003FFFEA, 31'h001FFFFD, 31'h000FFFFF, 31'h0007FFFF,
    31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF, 31'h00007FFF,
    31'h00003FFF, 31'h00001FFF, 31'h00000FFF, 31'h000007FF,
    31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F,
    31'h0000003F, 31'h0000001F, 31'h0000000F, 31'h00000008,
    31'h00000004, 31'h00000002, 31'h00000001, 31'h00000000
  };

  function automatic logic [ATAN_W-1:0] atan_of(input logic [STAGE_W-1:0] s);
    return ATAN_TAB[s];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sp2c_if.sv -----
// sp2c_if: valid/ready channel interfaces for samples, points and
// register writes. Depends on sp2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sp2c_sample_if
  import sp2c_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [RANGE_IN_W-1:0] range_mm;
  logic [IDX_W-1:0]      point_index;
  logic                  scan_last;

  modport source (output valid, range_mm, point_index, scan_last, input ready);
  modport sink   (input valid, range_mm, point_index, scan_last, output ready);
endinterface

interface sp2c_point_if
  import sp2c_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] x_mm;
  logic signed [OUT_W-1:0] y_mm;
  logic                    point_last;

  modport source (output valid, x_mm, y_mm, point_last, input ready);
  modport sink   (input valid, x_mm, y_mm, point_last, output ready);
endinterface

interface sp2c_cfg_if
  import sp2c_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sp2c_front.sv -----
// sp2c_front: two-stage front end, sample angle then Q30 angle and
// gain-scaled range. Depends on sp2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sp2c_front
  import sp2c_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [RANGE_IN_W-1:0]        range_mm,
  input  wire logic [IDX_W-1:0]             point_index,
  input  wire logic                         scan_last,
  input  wire logic signed [CFG_DATA_W-1:0] start_angle,
  input  wire logic signed [CFG_DATA_W-1:0] angle_step,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output cordic_t                           out_d
);

  localparam int SUM_W = IDX_W + CFG_DATA_W + 1;
  localparam int ZP_W  = ANGLE_BITS - 2 + HALF_PI_W + 1;
  localparam logic [ZP_W-1:0] Z_RND = ZP_W'(1) << (ANGLE_BITS - 3);

  // stage 1
  logic                  a_valid_r;
  logic [ANGLE_BITS-1:0] ang_r;
  logic [RANGE_BITS-1:0] range_r;
  logic                  a_last_r;
  logic                  a_ready;

  logic [IDX_W-1:0]       idx_c;
  logic signed [SUM_W-1:0] ang_sum;

  always_comb begin
    idx_c = point_index;
    if (32'(point_index) > MAX_POINTS - 1) begin
      idx_c = IDX_W'(MAX_POINTS - 1);
    end
    ang_sum = $signed({1'b0, idx_c}) * angle_step + SUM_W'(start_angle);
  end

  assign in_ready = !a_valid_r || a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      ang_r    <= ang_sum[ANGLE_BITS-1:0];
      range_r  <= RANGE_BITS'(range_mm);
      a_last_r <= scan_last;
    end
  end

  // stage 2: quadrant split, angle to Q30 radians, range times gain
  logic                          b_valid_r;
  cordic_t                       b_d_r;
  logic [ZP_W-1:0]               z_prod;
  logic [RANGE_BITS+GAIN_W-1:0]  x_prod;
  cordic_t                       b_d_nxt;

  always_comb begin
    z_prod       = ang_r[ANGLE_BITS-3:0] * HALF_PI_Q30 + Z_RND;
    x_prod       = range_r * GAIN_Q30;
    b_d_nxt.x    = XY_W'(x_prod);
    b_d_nxt.y    = '0;
    b_d_nxt.z    = Z_W'(z_prod >> (ANGLE_BITS - 2));
    b_d_nxt.quad = ang_r[ANGLE_BITS-1:ANGLE_BITS-2];
    b_d_nxt.last = a_last_r;
  end

  assign a_ready = !b_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_ready) begin
      b_valid_r <= a_valid_r;
    end
    if (a_ready && a_valid_r) begin
      b_d_r <= b_d_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_d     = b_d_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sp2c_cell.sv -----
// sp2c_cell: one CORDIC micro-rotation stage with its own register.
// Depends on sp2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sp2c_cell
  import sp2c_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [STAGE_W-1:0] stage,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cordic_t            in_d,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cordic_t                 out_d
);

  logic                   valid_r;
  cordic_t                d_r;
  cordic_t                d_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  at;

  always_comb begin
    xs    = in_d.x >>> stage;
    ys    = in_d.y >>> stage;
    at    = Z_W'(atan_of(stage));
    d_nxt = in_d;
    if (!in_d.z[Z_W-1]) begin
      d_nxt.x = in_d.x - ys;
      d_nxt.y = in_d.y + xs;
      d_nxt.z = in_d.z - at;
    end else begin
      d_nxt.x = in_d.x + ys;
      d_nxt.y = in_d.y - xs;
      d_nxt.z = in_d.z + at;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sp2c_post.sv -----
// sp2c_post: residual-angle correction, quadrant swap, rounding and
// saturation into the output register. Depends on sp2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sp2c_post
  import sp2c_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cordic_t            in_d,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [OUT_W-1:0] x_mm,
  output logic signed [OUT_W-1:0] y_mm,
  output logic                    point_last
);

  localparam int SH_W = XY_W - 15;
  localparam int P_W  = SH_W + RES_Z_W;
  localparam logic signed [XY_W-1:0] HALF_Q30 = XY_W'(1) <<< 29;

  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] r;
    logic signed [OUT_W-1:0] res;
    r = (v + HALF_Q30) >>> 30;
    if (r > OUT_LIMIT) begin
      res = OUT_W'(OUT_LIMIT);
    end else if (r < -OUT_LIMIT) begin
      res = OUT_W'(-OUT_LIMIT);
    end else begin
      res = OUT_W'(r);
    end
    return res;
  endfunction

  // stage 1: cross products with the residual angle
  logic                   p_valid_r;
  logic signed [P_W-1:0]  px_r;
  logic signed [P_W-1:0]  py_r;
  logic signed [XY_W-1:0] p_x_r;
  logic signed [XY_W-1:0] p_y_r;
  logic [1:0]             p_quad_r;
  logic                   p_last_r;
  logic                   p_ready;

  logic signed [XY_W-1:0]    xsh_full;
  logic signed [XY_W-1:0]    ysh_full;
  logic signed [SH_W-1:0]    xsh;
  logic signed [SH_W-1:0]    ysh;
  logic signed [RES_Z_W-1:0] zr;

  always_comb begin
    xsh_full = in_d.x >>> 15;
    ysh_full = in_d.y >>> 15;
    xsh      = xsh_full[SH_W-1:0];
    ysh      = ysh_full[SH_W-1:0];
    zr       = in_d.z[RES_Z_W-1:0];   // residual is small after the last cell
  end

  assign in_ready = !p_valid_r || p_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_ready) begin
      p_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      px_r     <= xsh * zr;
      py_r     <= ysh * zr;
      p_x_r    <= in_d.x;
      p_y_r    <= in_d.y;
      p_quad_r <= in_d.quad;
      p_last_r <= in_d.last;
    end
  end

  // stage 2: apply the correction
  logic                   c_valid_r;
  logic signed [XY_W-1:0] c_x_r;
  logic signed [XY_W-1:0] c_y_r;
  logic [1:0]             c_quad_r;
  logic                   c_last_r;
  logic                   c_ready;

  assign p_ready = !c_valid_r || c_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (p_ready) begin
      c_valid_r <= p_valid_r;
    end
    if (p_ready && p_valid_r) begin
      c_x_r    <= p_x_r - XY_W'(py_r >>> 15);
      c_y_r    <= p_y_r + XY_W'(px_r >>> 15);
      c_quad_r <= p_quad_r;
      c_last_r <= p_last_r;
    end
  end

  // stage 3: quadrant swap, round, saturate into the output register
  logic                    o_valid_r;
  logic signed [OUT_W-1:0] o_x_r;
  logic signed [OUT_W-1:0] o_y_r;
  logic                    o_last_r;
  logic signed [XY_W-1:0]  rx;
  logic signed [XY_W-1:0]  ry;

  always_comb begin
    case (c_quad_r)
      2'd1: begin
        rx = -c_y_r;
        ry = c_x_r;
      end
      2'd2: begin
        rx = -c_x_r;
        ry = -c_y_r;
      end
      2'd3: begin
        rx = c_y_r;
        ry = -c_x_r;
      end
      default: begin
        rx = c_x_r;
        ry = c_y_r;
      end
    endcase
  end

  assign c_ready = !o_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (c_ready) begin
      o_valid_r <= c_valid_r;
    end
    if (c_ready && c_valid_r) begin
      o_x_r    <= round_sat(rx);
      o_y_r    <= round_sat(ry);
      o_last_r <= c_last_r;
    end
  end

  assign out_valid  = o_valid_r;
  assign x_mm       = o_x_r;
  assign y_mm       = o_y_r;
  assign point_last = o_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/scan_polar_to_cartesian.sv -----
// scan_polar_to_cartesian: top level, front end, CORDIC cell chain and
// output stage. Depends on sp2c_pkg, sp2c_if, sp2c_front, sp2c_cell, sp2c_post.
//
// Usage
//   in_pt  : range samples (range_mm, point_index, scan_last); one
//            transaction per sample on valid && ready.
//   out_pt : points (x_mm, y_mm, point_last); one transaction per sample,
//            in input order.
//   cfg_wr : register writes, index 0 = start_angle, 1 = angle_step, other
//            indexes are ignored. Always ready; write only while idle.
// The result path runs through the two front-end registers, one register
//   per CORDIC cell and the three output-side registers.
// Throughput is one sample per cycle while out_pt.ready is high: each
//   stage has its own register and valid bit, so samples go back to back.
// Reset (synchronous, active low) empties the pipeline and clears both
//   angle registers to zero.
// When the receiver stalls, the output register holds its point. Ready runs
//   back through every stage in the same cycle, but a stage that holds no
//   sample keeps accepting, so in_pt.ready only drops once every stage
//   holds a sample.
`timescale 1ns / 1ps
`default_nettype none

module scan_polar_to_cartesian
  import sp2c_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sp2c_sample_if.sink   in_pt,
  sp2c_point_if.source  out_pt,
  sp2c_cfg_if.sink      cfg_wr
);

  // configuration registers
  logic signed [CFG_DATA_W-1:0] start_angle_r;
  logic signed [CFG_DATA_W-1:0] angle_step_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_START_ANGLE: start_angle_r <= cfg_wr.data;
        REG_ANGLE_STEP:  angle_step_r  <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // links between stages: entry g feeds cell g, the last entry feeds the
  // output stage
  cordic_t link_d     [CORDIC_STAGES+1];
  logic    link_valid [CORDIC_STAGES+1];
  logic    link_ready [CORDIC_STAGES+1];

  sp2c_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_pt.valid),
    .in_ready    (in_pt.ready),
    .range_mm    (in_pt.range_mm),
    .point_index (in_pt.point_index),
    .scan_last   (in_pt.scan_last),
    .start_angle (start_angle_r),
    .angle_step  (angle_step_r),
    .out_valid   (link_valid[0]),
    .out_ready   (link_ready[0]),
    .out_d       (link_d[0])
  );

  // micro-rotation chain, cell g shifts by g
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    sp2c_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage     (STAGE_W'(g)),
      .in_valid  (link_valid[g]),
      .in_ready  (link_ready[g]),
      .in_d      (link_d[g]),
      .out_valid (link_valid[g+1]),
      .out_ready (link_ready[g+1]),
      .out_d     (link_d[g+1])
    );
  end

  sp2c_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (link_valid[CORDIC_STAGES]),
    .in_ready   (link_ready[CORDIC_STAGES]),
    .in_d       (link_d[CORDIC_STAGES]),
    .out_valid  (out_pt.valid),
    .out_ready  (out_pt.ready),
    .x_mm       (out_pt.x_mm),
    .y_mm       (out_pt.y_mm),
    .point_last (out_pt.point_last)
  );

endmodule

`default_nettype wire
